### rtl/core/sorted_unique_key_list_unit_assert.svh
// Assertion macros used by the key list RTL.
`ifndef SORTED_UNIQUE_KEY_LIST_UNIT_ASSERT_SVH
`define SORTED_UNIQUE_KEY_LIST_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on the rising clock edge outside reset.
`define SULU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Check a property on every rising clock edge, reset included.
`define SULU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define SULU_ASSERT(lbl, prop, msg)
`define SULU_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/core/sulu_pkg.sv
package sulu_pkg;

    localparam int CAPACITY   = 32;
    localparam int KEY_BITS   = 32;
    localparam int KEY_IN_W   = 32;
    localparam int ACTION_W   = 2;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 6;
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    typedef logic [KEY_BITS-1:0] t_key;
    typedef logic [CNT_W-1:0]    t_cnt;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NOP    = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_APPLY
    } t_state;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic cmp_en;
        logic ins;
        logic rem;
    } t_cell_ctrl;

endpackage

### rtl/core/sulu_cell.sv
module sulu_cell
    import sulu_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  t_key       i_req_key,
    input  logic       i_vld,
    input  t_key       i_left_key,
    input  logic       i_left_g,
    input  t_key       i_right_key,
    output t_key       o_key,
    output logic       o_g,
    output logic       o_eq
);

    t_key r_key;
    logic r_gt;
    logic r_eq;
    logic r_vld;
    t_key n_key;

    // Empty slots count as larger, so the insert point is the first set flag.
    assign o_g   = r_gt | ~r_vld;
    assign o_eq  = r_eq;
    assign o_key = r_key;

    // Latch compare flags against the request key.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp_en) begin
            r_vld <= i_vld;
            r_eq  <= i_vld && (r_key == i_req_key);
            r_gt  <= i_vld && (r_key > i_req_key);
        end
    end

    // Shift up on insert, down on remove, or hold.
    always_comb begin
        n_key = r_key;
        if (i_ctrl.ins && o_g) begin
            n_key = i_left_g ? i_left_key : i_req_key;
        end else if (i_ctrl.rem && (r_gt || r_eq)) begin
            n_key = i_right_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

### rtl/core/sorted_unique_key_list_unit.sv
// Sorted unique key list: a row of key cells, one per entry.
// Result strobe o_done is registered after the compare and apply states that follow the start beat.
// Requests do not overlap: busy stays high through the cell compare and cell shift states of each one.
// Reset: synchronous, active low; clears the count and control, not stored keys.
// The receiver cannot stall: each result shows on o_done for one cycle.
`include "sorted_unique_key_list_unit_assert.svh"

module sorted_unique_key_list_unit
    import sulu_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [KEY_IN_W-1:0] i_key,
    output logic                o_done,
    output logic [STATUS_W-1:0] o_status,
    output logic [COUNT_W-1:0]  o_count
);

    t_state                r_state;
    t_state                n_state;
    t_cnt                  r_count;
    t_cnt                  n_count;
    logic [ACTION_W-1:0]   r_action;
    t_key                  r_key;
    logic                  r_done;
    logic                  n_done;
    t_status               r_status;
    t_status               n_status;
    t_cell_ctrl            w_ctrl;

    t_key                  w_key [CAPACITY];
    logic [CAPACITY-1:0]   w_g;
    logic [CAPACITY-1:0]   w_eq;
    logic [CAPACITY-1:0]   w_vld;
    logic                  w_found;
    logic                  w_full;

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_status = r_status;
    assign o_count  = COUNT_W'(r_count);
    assign w_found  = |w_eq;
    assign w_full   = (r_count >= CNT_W'(CAPACITY));

    // Hold the request beat.
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_action <= i_action;
            r_key    <= KEY_BITS'(i_key);
        end
    end

    // State, count and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
    end

    // Sequence compare then apply; decide status and new count.
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_done   = 1'b0;
        n_status = r_status;
        w_ctrl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                w_ctrl.cmp_en = 1'b1;
                n_state       = S_APPLY;
            end
            S_APPLY: begin
                n_state  = S_IDLE;
                n_done   = 1'b1;
                n_status = ST_DONE;
                case (r_action)
                    ACT_INSERT: begin
                        if (w_found) begin
                            n_status = ST_MISS;
                        end else if (w_full) begin
                            n_status = ST_FULL;
                        end else begin
                            w_ctrl.ins = 1'b1;
                            n_count    = r_count + CNT_W'(1);
                        end
                    end
                    ACT_REMOVE: begin
                        if (w_found) begin
                            w_ctrl.rem = 1'b1;
                            n_count    = r_count - CNT_W'(1);
                        end else begin
                            n_status = ST_MISS;
                        end
                    end
                    ACT_CLEAR: begin
                        n_count = '0;
                    end
                    default: begin
                        n_status = ST_DONE;
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Build the cell row with neighbor links.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        t_key w_left_key;
        logic w_left_g;
        t_key w_right_key;

        assign w_vld[i] = (CNT_W'(i) < r_count);

        if (i == 0) begin : g_first
            assign w_left_key = '0;
            assign w_left_g   = 1'b0;
        end else begin : g_mid
            assign w_left_key = w_key[i-1];
            assign w_left_g   = w_g[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign w_right_key = w_key[i];
        end else begin : g_inner
            assign w_right_key = w_key[i+1];
        end

        sulu_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_req_key   (r_key),
            .i_vld       (w_vld[i]),
            .i_left_key  (w_left_key),
            .i_left_g    (w_left_g),
            .i_right_key (w_right_key),
            .o_key       (w_key[i]),
            .o_g         (w_g[i]),
            .o_eq        (w_eq[i])
        );
    end

    `SULU_ASSERT(a_apply_strobes, (r_state == S_APPLY) |=> r_done, "apply without result")
    `SULU_ASSERT(a_accept_cmp, (start && !busy) |=> (r_state == S_CMP), "start beat lost")
    `SULU_ASSERT(a_count_cap, r_count <= CNT_W'(CAPACITY), "count above capacity")
    `SULU_ASSERT(a_full_count, (r_done && (r_status == ST_FULL)) |-> w_full, "full status while not full")
    `SULU_ASSERT(a_done_idle, r_done |-> (r_state == S_IDLE), "result outside idle")

endmodule
